[sv/rotating_queue_move_to_front_core_defines.svh]
// Assertion helpers shared by the list core.
`ifndef ROTATING_QUEUE_MOVE_TO_FRONT_CORE_DEFINES_SVH
`define ROTATING_QUEUE_MOVE_TO_FRONT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every clock edge once reset is released.
`define RQMTF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RQMTF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RQMTF_ASSERT(lbl, clk, rst_n, prop, msg)
`define RQMTF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[sv/rqmtf_pkg.sv]
package rqmtf_pkg;

    localparam int unsigned ENTRY_W = 30;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned POP_W   = 30;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [CMD_W-1:0]   t_cmd_bits;

    typedef enum logic [CMD_W-1:0] {
        CMD_NEXT     = 2'd0,
        CMD_EXPEDITE = 2'd1,
        CMD_RESTART  = 2'd2
    } t_cmd;

    // Broadcast controls shared by every cell of the chain.
    typedef struct packed {
        logic restart;
        logic rotate;
        logic compare;
        logic shift;
    } t_cell_ctl;

endpackage

[sv/rqmtf_in_if.sv]
interface rqmtf_in_if;
    logic                      valid;
    logic                      ready;
    rqmtf_pkg::t_cmd_bits      cmd;
    rqmtf_pkg::t_entry         citizen_id;

    modport source (output valid, output cmd, output citizen_id, input ready);
    modport sink   (input valid, input cmd, input citizen_id, output ready);
endinterface

[sv/rqmtf_out_if.sv]
interface rqmtf_out_if;
    logic              valid;
    logic              ready;
    rqmtf_pkg::t_entry citizen;
    logic              served;
    logic              empty_res;
    logic              dropped;

    modport source (output valid, output citizen, output served, output empty_res,
                    output dropped, input ready);
    modport sink   (input valid, input citizen, input served, input empty_res,
                    input dropped, output ready);
endinterface

[sv/rqmtf_cell.sv]
module rqmtf_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 11
) (
    input  logic                 i_clk,
    input  rqmtf_pkg::t_cell_ctl i_ctl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic                 i_shift_en,
    input  rqmtf_pkg::t_entry    i_left,
    input  rqmtf_pkg::t_entry    i_right,
    input  rqmtf_pkg::t_entry    i_front,
    input  rqmtf_pkg::t_entry    i_id,
    output rqmtf_pkg::t_entry    o_entry,
    output logic                 o_match
);
    import rqmtf_pkg::*;

    t_entry r_entry;
    logic   r_match;
    logic   w_valid;
    logic   w_last;

    assign w_valid = (CNT_W'(IDX) < i_count);
    assign w_last  = (CNT_W'(IDX + 1) == i_count);

    always_ff @(posedge i_clk) begin
        if (i_ctl.restart) begin
            r_entry <= ENTRY_W'(IDX + 1);
        end else if (i_ctl.rotate) begin
            // last live entry takes the old front, the rest move up one place
            r_entry <= w_last ? i_front : i_right;
        end else if (i_ctl.shift && i_shift_en) begin
            r_entry <= i_left;
        end
        if (i_ctl.compare) begin
            r_match <= w_valid && (r_entry == i_id);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;
endmodule

[sv/rotating_queue_move_to_front_core.sv]
// Next, restart and unused commands: result registered in the cycle after accept,
// one beat per cycle while the result side keeps up.
// Expedite: a compare cycle in every cell and then a shift cycle set by the
// suffix-OR over the registered match bits; no new command is taken during the shift cycle.
// Reset (synchronous, active low) empties the list and sets population to 1;
// the entry cells are not cleared, so no clearing pass is needed.
`include "rotating_queue_move_to_front_core_defines.svh"

module rotating_queue_move_to_front_core #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rqmtf_pkg::POP_W-1:0] i_cfg_wdata,
    rqmtf_in_if.sink                  i_in,
    rqmtf_out_if.source               o_out
);
    import rqmtf_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned LVL   = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [POP_W-1:0]   r_pop;
    t_entry             r_id;
    logic               r_out_valid, n_out_valid;
    t_entry             r_citizen, n_citizen;
    logic               r_served, n_served;
    logic               r_empty, n_empty;
    logic               r_dropped, n_dropped;

    logic               w_accept;
    logic               w_found;
    t_cell_ctl          w_ctl;
    t_entry             w_entry [DEPTH];
    logic [DEPTH-1:0]   w_match;
    wire  [DEPTH-1:0]   w_suf [LVL+1];

    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_ctl.restart = w_accept && (i_in.cmd == CMD_RESTART);
    assign w_ctl.rotate  = w_accept && (i_in.cmd == CMD_NEXT) && (r_count != '0);
    assign w_ctl.compare = w_accept && (i_in.cmd == CMD_EXPEDITE);
    assign w_ctl.shift   = (r_state == ST_APPLY);

    // Suffix OR: bit i is set when the match lies at position i or further back.
    assign w_suf[0] = w_match;
    for (genvar l = 0; l < LVL; l++) begin : g_lvl
        for (genvar b = 0; b < DEPTH; b++) begin : g_bit
            if (b + (1 << l) < DEPTH) begin : g_or
                assign w_suf[l+1][b] = w_suf[l][b] | w_suf[l][b + (1 << l)];
            end else begin : g_pass
                assign w_suf[l+1][b] = w_suf[l][b];
            end
        end
    end
    assign w_found = w_suf[LVL][0];

    for (genvar c = 0; c < DEPTH; c++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        if (c == 0) begin : g_head
            assign w_left = r_id;
        end else begin : g_body
            assign w_left = w_entry[c-1];
        end
        if (c == DEPTH - 1) begin : g_tail
            assign w_right = w_entry[0];
        end else begin : g_mid
            assign w_right = w_entry[c+1];
        end

        rqmtf_cell #(
            .IDX   (c),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_shift_en (!w_found || w_suf[LVL][c]),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_front    (w_entry[0]),
            .i_id       (i_in.citizen_id),
            .o_entry    (w_entry[c]),
            .o_match    (w_match[c])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_out.ready;
        n_citizen   = r_citizen;
        n_served    = r_served;
        n_empty     = r_empty;
        n_dropped   = r_dropped;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_citizen = '0;
                    n_served  = 1'b0;
                    n_empty   = 1'b0;
                    n_dropped = 1'b0;
                    case (i_in.cmd)
                        CMD_NEXT: begin
                            n_out_valid = 1'b1;
                            if (r_count == '0) begin
                                n_empty = 1'b1;
                            end else begin
                                n_citizen = w_entry[0];
                                n_served  = 1'b1;
                            end
                        end
                        CMD_EXPEDITE: begin
                            // hold the result until the shift cycle
                            n_state = ST_APPLY;
                        end
                        CMD_RESTART: begin
                            n_out_valid = 1'b1;
                            if (r_pop >= POP_W'(DEPTH)) begin
                                n_count = DEPTH_C;
                            end else begin
                                n_count = r_pop[CNT_W-1:0];
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_APPLY: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                if (!w_found) begin
                    if (r_count != DEPTH_C) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pop       <= POP_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pop <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_citizen <= n_citizen;
        r_served  <= n_served;
        r_empty   <= n_empty;
        r_dropped <= n_dropped;
        if (w_ctl.compare) begin
            r_id <= i_in.citizen_id;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.citizen   = r_citizen;
    assign o_out.served    = r_served;
    assign o_out.empty_res = r_empty;
    assign o_out.dropped   = r_dropped;

    `RQMTF_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_C, "count above depth")
    `RQMTF_ASSERT(a_unique_match, i_clk, i_rst_n, (r_state == ST_APPLY) |-> $onehot0(w_match), "duplicate entry in list")
    `RQMTF_ASSERT(a_expedite_seq, i_clk, i_rst_n, w_ctl.compare |=> (r_state == ST_APPLY) && !r_out_valid, "expedite did not enter shift cycle")
    `RQMTF_ASSERT(a_flags_excl, i_clk, i_rst_n, r_out_valid |-> $onehot0({r_served, r_empty, r_dropped}), "result flags overlap")
endmodule
